// ----- rtl/dnstd_pkg.sv -----
// ----------------------------------------------------------------------------
// dnstd_pkg
// Shared types and constants of the DNS tunnel host detector.
// ----------------------------------------------------------------------------
`default_nettype none

package dnstd_pkg;

    localparam int NAME_W  = 8;
    localparam int IP_W    = 32;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 17;
    localparam int LIMIT_W = 16;
    localparam int TENTH_W = 4;
    localparam int CIDX_W  = 8;
    localparam int CDATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [NAME_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [NAME_W-1:0] CHAR_NINE = 8'h39;

    localparam logic [CIDX_W-1:0] CFG_EXPIRY      = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_COUNT_LIMIT = 8'd1;
    localparam logic [CIDX_W-1:0] CFG_MIN_LENGTH  = 8'd2;
    localparam logic [CIDX_W-1:0] CFG_TENTHS      = 8'd3;

    localparam logic [TIME_W-1:0]  RST_EXPIRY      = 32'd60;
    localparam logic [LIMIT_W-1:0] RST_COUNT_LIMIT = 16'd100;
    localparam logic [NAME_W-1:0]  RST_MIN_LENGTH  = 8'd32;
    localparam logic [TENTH_W-1:0] RST_TENTHS      = 4'd5;

    typedef enum logic [2:0] {
        VD_ADDED   = 3'd0,
        VD_FULL    = 3'd1,
        VD_EXPIRED = 3'd2,
        VD_COUNT   = 3'd3,
        VD_DIGITS  = 3'd4,
        VD_NORMAL  = 3'd5,
        VD_INVALID = 3'd6
    } verdict_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } back_state_t;

    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [TIME_W-1:0] now;
        logic [NAME_W-1:0] len;
        logic [NAME_W-1:0] digits;
        logic              ok;
    } query_t;

    typedef struct packed {
        logic               valid;
        logic [IP_W-1:0]    ip;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  created;
    } entry_t;

    typedef struct packed {
        logic [TIME_W-1:0]  expiry;
        logic [LIMIT_W-1:0] count_limit;
        logic [TENTH_W-1:0] tenths;
    } back_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/dnstd_front.sv -----
// ----------------------------------------------------------------------------
// dnstd_front
// Takes name characters, keeps running length and digit counts, and pushes
// one query descriptor per name on its last character.
// ----------------------------------------------------------------------------
`default_nettype none

module dnstd_front #(
    parameter int MAX_NAME_LENGTH = 255
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [71:0]                  s_tdata,
    input  wire logic [1:0]                   s_tuser,
    input  wire logic                         s_tlast,
    input  wire logic [dnstd_pkg::NAME_W-1:0] min_name_length,
    output logic                              q_valid,
    input  wire logic                         q_ready,
    output dnstd_pkg::query_t                 q_data
);

    localparam logic [dnstd_pkg::NAME_W-1:0] LEN_MAX = dnstd_pkg::NAME_W'(MAX_NAME_LENGTH);

    logic [dnstd_pkg::NAME_W-1:0] len_reg;
    logic [dnstd_pkg::NAME_W-1:0] len_next;
    logic [dnstd_pkg::NAME_W-1:0] dig_reg;
    logic [dnstd_pkg::NAME_W-1:0] dig_next;
    logic [dnstd_pkg::NAME_W-1:0] len_cur;
    logic [dnstd_pkg::NAME_W-1:0] dig_cur;
    logic [dnstd_pkg::NAME_W-1:0] ch;
    logic                         present;
    logic                         is_digit;
    logic                         accept;

    assign ch       = s_tdata[71:64];
    assign present  = s_tuser[0];
    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;
    assign q_valid  = s_tvalid && s_tlast;

    always_comb
    begin
        is_digit = ch inside {[dnstd_pkg::CHAR_ZERO:dnstd_pkg::CHAR_NINE]};
        len_cur  = len_reg;
        dig_cur  = dig_reg;
        if (present && (len_reg < LEN_MAX))
        begin
            len_cur = len_reg + 1'b1;
        end
        if (present && is_digit && (dig_reg < LEN_MAX))
        begin
            dig_cur = dig_reg + 1'b1;
        end
        len_next = len_reg;
        dig_next = dig_reg;
        if (accept)
        begin
            len_next = s_tlast ? '0 : len_cur;
            dig_next = s_tlast ? '0 : dig_cur;
        end
    end

    always_comb
    begin
        q_data.ip     = s_tdata[31:0];
        q_data.now    = s_tdata[63:32];
        q_data.len    = len_cur;
        q_data.digits = (len_cur > min_name_length) ? dig_cur : '0;
        q_data.ok     = s_tuser[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            dig_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
            dig_reg <= dig_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dnstd_queue.sv -----
// ----------------------------------------------------------------------------
// dnstd_queue
// Two-entry queue of query descriptors between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dnstd_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire dnstd_pkg::query_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output dnstd_pkg::query_t       out_data
);

    dnstd_pkg::query_t slot_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic              push;
    logic              pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dnstd_back.sv -----
// ----------------------------------------------------------------------------
// dnstd_back
// Host table engine: clears the table after reset, scans it once per valid
// query for a matching host and the lowest free slot, then applies the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module dnstd_back #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dnstd_pkg::back_cfg_t  cfg,
    input  wire logic                  q_valid,
    output logic                       q_ready,
    input  wire dnstd_pkg::query_t     q_data,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    dnstd_pkg::entry_t      tbl_mem [TABLE_ENTRIES];

    dnstd_pkg::back_state_t state_reg;
    dnstd_pkg::back_state_t state_next;
    logic [IDX_W-1:0]       clr_addr_reg;
    logic [IDX_W-1:0]       clr_addr_next;
    logic [IDX_W-1:0]       scan_addr_reg;
    logic [IDX_W-1:0]       scan_addr_next;
    logic                   issue_done_reg;
    logic                   issue_done_next;
    logic                   rd_vld_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    dnstd_pkg::entry_t      rd_data_reg;
    dnstd_pkg::query_t      q_reg;
    logic                   hit_found_reg;
    logic                   hit_found_next;
    logic [IDX_W-1:0]       hit_idx_reg;
    logic [IDX_W-1:0]       hit_idx_next;
    logic [dnstd_pkg::COUNT_W-1:0] hit_count_reg;
    logic [dnstd_pkg::COUNT_W-1:0] hit_count_next;
    logic [dnstd_pkg::TIME_W-1:0]  hit_created_reg;
    logic [dnstd_pkg::TIME_W-1:0]  hit_created_next;
    logic                   free_found_reg;
    logic                   free_found_next;
    logic [IDX_W-1:0]       free_idx_reg;
    logic [IDX_W-1:0]       free_idx_next;
    logic                   over_reg;
    logic                   out_vld_reg;
    logic                   out_vld_next;
    logic [23:0]            out_data_reg;

    logic                   out_free;
    logic                   rd_en;
    logic                   pop;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    dnstd_pkg::entry_t      mem_wdata;
    logic                   res_load;
    dnstd_pkg::verdict_t    res_verdict;

    logic [11:0]                    digit_x10;
    logic [12:0]                    len_x_lim;
    logic [dnstd_pkg::TIME_W-1:0]   age;
    logic                           expired;
    logic [dnstd_pkg::COUNT_W-1:0]  cnt_inc;
    logic                           cnt_over;
    logic                           last_read;

    assign out_free  = !out_vld_reg || m_tready;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_data_reg;
    assign q_ready   = pop;
    assign last_read = rd_vld_reg && (rd_idx_reg == IDX_LAST);

    // digit share test: floor(10*d/len) > lim  <=>  10*d >= (lim+1)*len
    assign digit_x10 = {q_reg.digits, 3'b000} + {3'b000, q_reg.digits, 1'b0};
    assign len_x_lim = 13'({1'b0, cfg.tenths} + 5'd1) * 13'(q_reg.len);

    assign age      = q_reg.now - hit_created_reg;
    assign expired  = age > cfg.expiry;
    assign cnt_inc  = (hit_count_reg == dnstd_pkg::COUNT_MAX) ? hit_count_reg
                                                              : hit_count_reg + 1'b1;
    assign cnt_over = cnt_inc > dnstd_pkg::COUNT_W'(cfg.count_limit);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dnstd_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == IDX_LAST)
                begin
                    state_next = dnstd_pkg::ST_IDLE;
                end
            end
            dnstd_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_data.ok ? dnstd_pkg::ST_SCAN : dnstd_pkg::ST_DECIDE;
                end
            end
            dnstd_pkg::ST_SCAN:
            begin
                if (last_read)
                begin
                    state_next = dnstd_pkg::ST_DECIDE;
                end
            end
            dnstd_pkg::ST_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = dnstd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dnstd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_we      = 1'b0;
        mem_waddr   = hit_idx_reg;
        mem_wdata   = '{valid: 1'b1, ip: q_reg.ip, count: cnt_inc,
                        created: hit_created_reg};
        rd_en       = 1'b0;
        pop         = 1'b0;
        res_load    = 1'b0;
        res_verdict = dnstd_pkg::VD_NORMAL;
        case (state_reg)
            dnstd_pkg::ST_CLEAR:
            begin
                mem_we          = 1'b1;
                mem_waddr       = clr_addr_reg;
                mem_wdata.valid = 1'b0;
            end
            dnstd_pkg::ST_IDLE:
            begin
                pop = q_valid;
            end
            dnstd_pkg::ST_SCAN:
            begin
                rd_en = !issue_done_reg;
            end
            dnstd_pkg::ST_DECIDE:
            begin
                res_load = out_free;
                if (!q_reg.ok)
                begin
                    res_verdict = dnstd_pkg::VD_INVALID;
                end
                else if (!hit_found_reg)
                begin
                    if (free_found_reg)
                    begin
                        res_verdict = dnstd_pkg::VD_ADDED;
                        mem_we      = out_free;
                        mem_waddr   = free_idx_reg;
                        mem_wdata   = '{valid: 1'b1, ip: q_reg.ip, count: 17'd1,
                                        created: q_reg.now};
                    end
                    else
                    begin
                        res_verdict = dnstd_pkg::VD_FULL;
                    end
                end
                else if (expired)
                begin
                    res_verdict     = dnstd_pkg::VD_EXPIRED;
                    mem_we          = out_free;
                    mem_wdata.valid = 1'b0;
                end
                else if (cnt_over)
                begin
                    res_verdict     = dnstd_pkg::VD_COUNT;
                    mem_we          = out_free;
                    mem_wdata.valid = 1'b0;
                end
                else
                begin
                    res_verdict = over_reg ? dnstd_pkg::VD_DIGITS : dnstd_pkg::VD_NORMAL;
                    mem_we      = out_free;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        clr_addr_next    = clr_addr_reg;
        scan_addr_next   = scan_addr_reg;
        issue_done_next  = issue_done_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        hit_count_next   = hit_count_reg;
        hit_created_next = hit_created_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        out_vld_next     = out_vld_reg;
        if (state_reg == dnstd_pkg::ST_CLEAR)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end
        if (pop)
        begin
            scan_addr_next  = '0;
            issue_done_next = 1'b0;
            hit_found_next  = 1'b0;
            free_found_next = 1'b0;
        end
        if (rd_en)
        begin
            scan_addr_next  = scan_addr_reg + 1'b1;
            issue_done_next = (scan_addr_reg == IDX_LAST);
        end
        if (rd_vld_reg)
        begin
            if (rd_data_reg.valid)
            begin
                if (!hit_found_reg && (rd_data_reg.ip == q_reg.ip))
                begin
                    hit_found_next   = 1'b1;
                    hit_idx_next     = rd_idx_reg;
                    hit_count_next   = rd_data_reg.count;
                    hit_created_next = rd_data_reg.created;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = rd_idx_reg;
            end
        end
        if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
        if (res_load)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tbl_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= tbl_mem[scan_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg      <= scan_addr_reg;
        hit_idx_reg     <= hit_idx_next;
        hit_count_reg   <= hit_count_next;
        hit_created_reg <= hit_created_next;
        free_idx_reg    <= free_idx_next;
        over_reg        <= (q_reg.len != '0) && ({1'b0, digit_x10} >= len_x_lim);
        if (pop)
        begin
            q_reg <= q_data;
        end
        if (res_load)
        begin
            out_data_reg <= {5'd0, q_reg.digits, q_reg.len, 3'(res_verdict)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dnstd_pkg::ST_CLEAR;
            clr_addr_reg   <= '0;
            scan_addr_reg  <= '0;
            issue_done_reg <= 1'b1;
            rd_vld_reg     <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            scan_addr_reg  <= scan_addr_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= rd_en;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            out_vld_reg    <= out_vld_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dns_tunnel_host_detector_top.sv -----
// Path: descriptor through the two-entry queue to the back, a table scan for a
//   valid record (one table read per cycle), then a registered verdict.
// Throughput: one character per cycle while the queue has room; the back takes
//   a query only after finishing the last; the host table has a single read port.
// Reset: asynchronous, active low; the table is then cleared one entry per
//   cycle, every entry in turn, before the first query is looked up.
// ----------------------------------------------------------------------------
// dns_tunnel_host_detector_top
// Per-host DNS query tracking with expiry, rate and digit-share checks.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_tunnel_host_detector_top #(
    parameter int TABLE_ENTRIES   = 64,
    parameter int MAX_NAME_LENGTH = 255
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // host_ip[31:0], now_seconds[63:32], name_char[71:64]
    input  wire logic [71:0]                    s_tdata,
    // char_present[0], record_ok[1]
    input  wire logic [1:0]                     s_tuser,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // verdict[2:0], name_length[10:3], digit_total[18:11], zero[23:19]
    output logic [23:0]                         m_tdata,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [dnstd_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [dnstd_pkg::CDATA_W-1:0]  cfg_data
);

    logic [dnstd_pkg::TIME_W-1:0]  expiry_reg;
    logic [dnstd_pkg::LIMIT_W-1:0] count_limit_reg;
    logic [dnstd_pkg::NAME_W-1:0]  min_len_reg;
    logic [dnstd_pkg::TENTH_W-1:0] tenths_reg;
    dnstd_pkg::back_cfg_t          back_cfg;
    logic                          cfg_we;

    logic                          fq_valid;
    logic                          fq_ready;
    dnstd_pkg::query_t             fq_data;
    logic                          qb_valid;
    logic                          qb_ready;
    dnstd_pkg::query_t             qb_data;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expiry_reg      <= dnstd_pkg::RST_EXPIRY;
            count_limit_reg <= dnstd_pkg::RST_COUNT_LIMIT;
            min_len_reg     <= dnstd_pkg::RST_MIN_LENGTH;
            tenths_reg      <= dnstd_pkg::RST_TENTHS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dnstd_pkg::CFG_EXPIRY:      expiry_reg      <= cfg_data;
                dnstd_pkg::CFG_COUNT_LIMIT: count_limit_reg <= cfg_data[15:0];
                dnstd_pkg::CFG_MIN_LENGTH:  min_len_reg     <= cfg_data[7:0];
                dnstd_pkg::CFG_TENTHS:      tenths_reg      <= cfg_data[3:0];
                default:                    tenths_reg      <= tenths_reg;
            endcase
        end
    end

    always_comb
    begin
        back_cfg.expiry      = expiry_reg;
        back_cfg.count_limit = count_limit_reg;
        back_cfg.tenths      = tenths_reg;
    end

    dnstd_front #(
        .MAX_NAME_LENGTH (MAX_NAME_LENGTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .min_name_length (min_len_reg),
        .q_valid         (fq_valid),
        .q_ready         (fq_ready),
        .q_data          (fq_data)
    );

    dnstd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    dnstd_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (back_cfg),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_data   (qb_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- rtl/dnstd_checker.sv -----
// ----------------------------------------------------------------------------
// dnstd_checker
// Port-level checks on the result stream of the detector.
// ----------------------------------------------------------------------------
`default_nettype none

module dnstd_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] != 3'd7)
        else $error("verdict code out of range");

    a_digits_le_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[18:11] <= m_tdata[10:3])
        else $error("digit total exceeds name length");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:19] == 5'd0)
        else $error("result padding not zero");

endmodule

bind dns_tunnel_host_detector_top dnstd_checker u_dnstd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
